// ----- rtl/core/rmt_pkg.sv -----
// rmt_pkg: shared types and constants for the range-minimum tree core.
// No dependencies.
`timescale 1ns / 1ps
package rmt_pkg;
  localparam int ValueW = 31;
  localparam int IdxW   = 10;
  localparam int OpW    = 2;
  localparam int Leaves = 1 << IdxW;  // leaf slots, one per index value
  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [OpW-1:0] op_t;
  localparam op_t OP_LOWER = 2'd0;
  localparam op_t OP_QUERY = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam value_t EMPTY_VALUE = 31'sd1000000000;

  // One level's request travelling down the chain of cells.
  typedef struct packed {
    logic            active;   // a request is in flight at this level
    op_t             op;
    logic [IdxW:0]   lo;       // running left bound (node index within level)
    logic [IdxW:0]   hi;       // running right bound, exclusive
    value_t          acc;      // query accumulator / update carry
  } walk_t;
endpackage

// ----- rtl/core/rmt_level.sv -----
// rmt_level: one tree level. Holds its node memory and works one step.
// Depends on rmt_pkg.
`timescale 1ns / 1ps
module rmt_level #(
  parameter int LEVEL = 0           // 0 = leaves
) (
  input  logic clk,
  input  logic rst,
  input  logic clear_go,
  input  logic [rmt_pkg::IdxW-1:0] clear_addr,
  input  rmt_pkg::walk_t in_walk,
  output rmt_pkg::walk_t out_walk
);
  import rmt_pkg::*;
  localparam int N  = Leaves >> LEVEL;
  localparam int NW = (N > 1) ? $clog2(N) : 1;

  value_t mem [N];
  // registered read, then combine and hand on through out_walk.
  walk_t hold;
  value_t rd_a, rd_b;
  logic [NW-1:0] pa, pb;
  logic [IdxW:0] lo_n, hi_n;
  value_t acc_n, old_v, mine, sib;

  // query reads both range ends; update reads the sibling pair.
  always_comb begin
    if (N == 1) begin
      pa = '0;
      pb = '0;
    end else if (in_walk.op == OP_QUERY) begin
      pa = NW'(in_walk.lo);
      pb = NW'(in_walk.hi - 1'b1);
    end else begin
      pa = NW'({in_walk.lo[IdxW:1], 1'b0});
      pb = NW'({in_walk.lo[IdxW:1], 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[pa];
    rd_b <= mem[pb];
    if (clear_go) begin
      if ({1'b0, clear_addr} < (IdxW+1)'(N)) mem[NW'(clear_addr)] <= EMPTY_VALUE;
    end else if (hold.active && hold.op == OP_LOWER) begin
      mem[NW'(hold.lo)] <= mine;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold.active <= 1'b0;
    end else begin
      hold.active <= in_walk.active;
    end
    hold.op  <= in_walk.op;
    hold.lo  <= in_walk.lo;
    hold.hi  <= in_walk.hi;
    hold.acc <= in_walk.acc;
  end

  always_comb begin
    lo_n  = hold.lo;
    hi_n  = hold.hi;
    acc_n = hold.acc;
    // update: leaves lower in place; inner levels take the child minimum.
    old_v = hold.lo[0] ? rd_b : rd_a;
    sib   = hold.lo[0] ? rd_a : rd_b;
    mine  = hold.acc;
    if (LEVEL == 0 && old_v < hold.acc) mine = old_v;
    if (N == 1) sib = mine;
    if (hold.op == OP_QUERY) begin
      if (lo_n < hi_n) begin
        if (lo_n[0]) begin
          if (rd_a < acc_n) acc_n = rd_a;
          lo_n = lo_n + 1'b1;
        end
        if (hi_n[0] && lo_n < hi_n) begin
          if (rd_b < acc_n) acc_n = rd_b;
          hi_n = hi_n - 1'b1;
        end
      end
      lo_n = lo_n >> 1;
      hi_n = hi_n >> 1;
    end else begin
      lo_n  = hold.lo >> 1;
      acc_n = (sib < mine) ? sib : mine;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_walk.active <= 1'b0;
    end else begin
      out_walk.active <= hold.active;
    end
    out_walk.op  <= hold.op;
    out_walk.lo  <= lo_n;
    out_walk.hi  <= hi_n;
    out_walk.acc <= acc_n;
  end
endmodule

// ----- rtl/core/range_min_tree_core.sv -----
// range_min_tree_core: top level, a chain of level cells plus clear sweep.
// Depends on rmt_pkg and rmt_level.
//
//  channel | handshake             | payload                                  | dir
//  in      | valid / ready         | operation, index, range_low, range_high, | request in
//          |                       | value                                    |
//  out     | out_valid / out_ready | minimum                                  | result out
//
// A request walks 11 level cells, each a registered read then a combine:
// the result register loads when the root cell's output is valid, and ready
// returns in the same cycle; the core takes no new request until then.
// Clear sweeps Leaves rows, one per cycle, all levels at once.
// After reset the same sweep runs before ready rises.
// One request in flight. A finished result that finds the output register
// still held waits in a pending register; ready stays low until it moves.
`timescale 1ns / 1ps
module range_min_tree_core (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [rmt_pkg::OpW-1:0] operation,
  input  logic [rmt_pkg::IdxW-1:0] index,
  input  logic [rmt_pkg::IdxW-1:0] range_low,
  input  logic [rmt_pkg::IdxW-1:0] range_high,
  input  logic signed [rmt_pkg::ValueW-1:0] value,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [rmt_pkg::ValueW-1:0] minimum
);
  import rmt_pkg::*;
  localparam int AW = IdxW;
  localparam int LV = AW + 1;             // level cells, leaves to root
  localparam int WalkLast = 2 * LV - 1;   // count when the root cell output is valid

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_CLR  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;   // finished result waits for output register
  logic [1:0] state;
  logic [AW:0] cnt;
  op_t op_q;
  value_t pend;
  logic res_done;
  value_t res_val;
  logic slot_free;
  walk_t chain [LV+1];
  walk_t start;

  wire acc_in = valid && ready;
  assign ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Entry into the leaf cell: saturate the query high end, empty range
  // when low is above high, drop an update to a leaf that does not exist.
  always_comb begin
    logic [IdxW:0] hs;
    hs = ({1'b0, range_high} >= (IdxW+1)'(Leaves)) ? (IdxW+1)'(Leaves - 1)
                                                   : {1'b0, range_high};
    start.active = acc_in && (operation == OP_QUERY || operation == OP_LOWER);
    start.op  = operation;
    start.acc = (operation == OP_QUERY) ? EMPTY_VALUE : value;
    if (operation == OP_QUERY) begin
      start.lo = {1'b0, range_low};
      start.hi = ({1'b0, range_low} > hs) ? start.lo : hs + 1'b1;
    end else begin
      start.lo = {1'b0, index};
      start.hi = '0;
      if ({1'b0, index} >= (IdxW+1)'(Leaves)) start.active = 1'b0;
    end
  end
  assign chain[0] = start;

  wire clear_go = (state == S_CLR);
  genvar g;
  generate
    for (g = 0; g < LV; g++) begin : g_lvl
      rmt_level #(.LEVEL(g)) u_lvl (
        .clk, .rst, .clear_go, .clear_addr(cnt[AW-1:0]),
        .in_walk(chain[g]), .out_walk(chain[g+1]));
    end
  endgenerate

  // Result ready this cycle; non-query requests answer zero.
  always_comb begin
    res_done = 1'b0;
    res_val  = '0;
    case (state)
      S_WALK: begin
        res_done = (cnt == (AW+1)'(WalkLast));
        res_val  = (op_q == OP_QUERY) ? chain[LV].acc : '0;
      end
      S_CLR: begin
        res_done = (cnt == (AW+1)'(Leaves - 1)) && (op_q == OP_CLEAR);
      end
      S_OUT: begin
        res_done = 1'b1;
        res_val  = pend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt <= '0;
      op_q <= OP_LOWER;
      out_valid <= 1'b0;
    end else begin
      if (res_done && slot_free) begin
        minimum <= res_val;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (acc_in) begin
          op_q <= operation;
          cnt <= '0;
          if (operation == OP_CLEAR) state <= S_CLR;
          else state <= S_WALK;
        end
        S_WALK: begin
          if (res_done) begin
            if (slot_free) begin
              state <= S_IDLE;
            end else begin
              pend <= res_val;
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CLR: begin
          if (cnt == (AW+1)'(Leaves - 1)) begin
            cnt <= '0;
            // reset sweep just ends; a clear request answers
            if (op_q == OP_CLEAR && !slot_free) begin
              pend <= '0;
              state <= S_OUT;
            end else state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: if (slot_free) begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pend: assert property (@(posedge clk) disable iff (rst) state == S_OUT |-> out_valid)
    else $error("pending result with free output register");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> cnt <= (AW+1)'(WalkLast)) else $error("walk count overrun");
  a_known: assert property (@(posedge clk) disable iff (rst) out_valid |-> !$isunknown(minimum))
    else $error("unknown result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(minimum)) else $error("result dropped");
endmodule

// ----- dv/range_min_tree_core_tb.sv -----
// range_min_tree_core_tb: self-checking bench for the range-minimum tree core.
// Depends on rmt_pkg and range_min_tree_core; keeps its own tree of minima.
`timescale 1ns / 1ps
module range_min_tree_core_tb;
  import rmt_pkg::*;

  localparam int NumLeaves = Leaves;
  localparam int LatencyCycles = 40;
  localparam longint CycleLimit = 400000;
  localparam op_t OP_SPARE = 2'd3;  // unused operation code

  typedef struct {
    op_t             op;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    value_t          val;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [OpW-1:0] operation = '0;
  logic [IdxW-1:0] index = '0;
  logic [IdxW-1:0] range_low = '0;
  logic [IdxW-1:0] range_high = '0;
  logic signed [ValueW-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ValueW-1:0] minimum;

  range_min_tree_core dut (
    .clk, .rst, .valid, .ready, .operation, .index, .range_low, .range_high,
    .value, .out_valid, .out_ready, .minimum
  );

  always #6 clk = ~clk;

  // Shadow tree of minima: leaf i at node NumLeaves+i.
  value_t   shadow_tree [2*NumLeaves];
  request_t pending_requests[$];
  value_t   expected_minima[$];
  int       error_count = 0;
  longint   cycle_count = 0;

  function automatic void clear_shadow();
    for (int n = 0; n < 2*NumLeaves; n++) shadow_tree[n] = EMPTY_VALUE;
  endfunction

  function automatic value_t min_of(value_t a, value_t b);
    return (a < b) ? a : b;
  endfunction

  // Advance the shadow tree by one request and return its expected minimum.
  function automatic value_t predict_minimum(request_t r);
    int lo_n, hi_n, p;
    value_t acc;
    acc = '0;
    case (r.op)
      OP_LOWER: begin
        p = NumLeaves + r.idx;
        shadow_tree[p] = min_of(shadow_tree[p], r.val);
        for (p = p >> 1; p >= 1; p = p >> 1)
          shadow_tree[p] = min_of(shadow_tree[2*p], shadow_tree[2*p+1]);
      end
      OP_QUERY: begin
        acc = EMPTY_VALUE;
        if (r.lo <= r.hi) begin
          lo_n = NumLeaves + r.lo;
          hi_n = NumLeaves + r.hi + 1;
          while (lo_n < hi_n) begin
            if (lo_n[0]) begin
              acc = min_of(acc, shadow_tree[lo_n]);
              lo_n++;
            end
            if (hi_n[0]) begin
              hi_n--;
              acc = min_of(acc, shadow_tree[hi_n]);
            end
            lo_n = lo_n >> 1;
            hi_n = hi_n >> 1;
          end
        end
      end
      OP_CLEAR: clear_shadow();
      default: ;  // unused code: no change, answers zero
    endcase
    return acc;
  endfunction

  function automatic void push_request(op_t op, int idx, int lo, int hi, value_t v);
    request_t r;
    r.op = op;
    r.idx = IdxW'(idx);
    r.lo = IdxW'(lo);
    r.hi = IdxW'(hi);
    r.val = v;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // Random value: mostly in range, sometimes full field width or at/above empty.
  function automatic value_t random_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return value_t'($urandom());
    if (sel == 1) return EMPTY_VALUE + value_t'($urandom_range(0, 5));
    return value_t'($urandom_range(0, 2000000000)) - value_t'(1000000000);
  endfunction

  function automatic int random_leaf();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
  endfunction

  // Driver: one request at a time, random idle gap after each accepted one.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (valid && ready) begin
        expected_minima.insert(expected_minima.size(),
                               predict_minimum(pending_requests.pop_front()));
        send_gap = $urandom_range(0, 3);
      end
      if (!valid || ready) begin
        if (send_gap > 0) begin
          send_gap--;
          valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          valid      <= 1'b1;
          operation  <= pending_requests[0].op;
          index      <= pending_requests[0].idx;
          range_low  <= pending_requests[0].lo;
          range_high <= pending_requests[0].hi;
          value      <= pending_requests[0].val;
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall before each result, then compare with oldest.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_minima.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, minimum);
          error_count++;
        end else begin
          if (minimum !== expected_minima[0]) begin
            $display("%0t: minimum mismatch, expected %0d, actual %0d",
                     $time, expected_minima[0], minimum);
            error_count++;
          end
          void'(expected_minima.pop_front());
        end
        recv_gap = $urandom_range(0, 3);
        out_ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= (recv_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sel, a, b;
    clear_shadow();
    // Directed: extremes, every operation, each corner case.
    push_request(OP_QUERY, 0, 0, 1023, '0);            // fresh tree is empty
    push_request(OP_LOWER, 0, 0, 0, -31'sd1000000000);
    push_request(OP_LOWER, 1023, 0, 0, 31'sd1000000000);
    push_request(OP_LOWER, 1023, 0, 0, 31'sd5);
    push_request(OP_LOWER, 512, 0, 0, 31'sd1000000001); // above empty: no effect
    push_request(OP_LOWER, 511, 0, 0, {1'b1, 30'd0});   // most negative field value
    push_request(OP_LOWER, 300, 0, 0, {1'b0, {30{1'b1}}});
    push_request(OP_LOWER, 5, 0, 0, 31'sd7);
    push_request(OP_LOWER, 5, 0, 0, 31'sd9);            // higher value leaves leaf alone
    push_request(OP_QUERY, 0, 0, 1023, '0);
    push_request(OP_QUERY, 0, 1023, 1023, '0);
    push_request(OP_QUERY, 0, 512, 1023, '0);
    push_request(OP_QUERY, 0, 1, 510, '0);
    push_request(OP_QUERY, 0, 5, 5, '0);
    push_request(OP_QUERY, 0, 6, 5, '0);                // low above high
    push_request(OP_QUERY, 0, 1023, 0, '0);
    push_request(OP_SPARE, 1023, 1023, 1023, {31{1'b1}}); // unused code
    push_request(OP_QUERY, 0, 0, 1023, '0);
    push_request(OP_CLEAR, 0, 0, 0, '0);
    push_request(OP_QUERY, 0, 0, 1023, '0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Random: mostly lowers and queries over a small hot region.
    for (int n = 0; n < 1130; n++) begin
      if (n == 560) begin
        // drain fully before continuing
        wait (pending_requests.size() == 0 && !valid && expected_minima.size() == 0);
      end
      sel = $urandom_range(0, 99);
      a = random_leaf();
      b = random_leaf();
      if (sel < 45)       push_request(OP_LOWER, a, $urandom(), $urandom(), random_value());
      else if (sel < 93)  push_request(OP_QUERY, $urandom(), (a < b) ? a : b,
                                       ($urandom_range(0, 4) == 0) ? a : ((a < b) ? b : a), '0);
      else if (sel < 96)  push_request(OP_CLEAR, $urandom(), $urandom(), $urandom(),
                                       random_value());
      else                push_request(OP_SPARE, $urandom(), $urandom(), $urandom(),
                                       random_value());
      if (pending_requests.size() > 8) wait (pending_requests.size() <= 4);
    end
    wait (pending_requests.size() == 0 && !valid && expected_minima.size() == 0);
    repeat (LatencyCycles) @(posedge clk);
    if (error_count == 0 && expected_minima.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
